@@ src/ltts_pkg.sv @@
// shared constants and types of the lru timestamp tag store
package ltts_pkg;

   localparam int unsigned MAX_ENTRIES = 32;
   localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned STAMP_W     = 32;
   localparam int unsigned SLOT_W      = 5;
   localparam int unsigned CAP_W       = 6;
   localparam int unsigned ACT_W       = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   typedef struct packed {
      logic               key_we;
      logic               stamp_we;
      logic [IDX_W-1:0]   addr;
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } ram_wr_type;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              replaced;
   } result_type;

endpackage

@@ src/ltts_if.sv @@
// request and response channel interfaces of the tag store
interface ltts_req_if;
   logic                                valid;
   logic                                ready;
   logic [ltts_pkg::ACT_W-1:0]          action;
   logic signed [ltts_pkg::KEY_W-1:0]   key;
   logic [ltts_pkg::STAMP_W-1:0]        now_ms;

   modport source (output valid, output action, output key, output now_ms, input ready);
   modport sink   (input valid, input action, input key, input now_ms, output ready);
endinterface

interface ltts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [ltts_pkg::SLOT_W-1:0]   slot;
   logic                          replaced;

   modport source (output valid, output hit, output slot, output replaced, input ready);
   modport sink   (input valid, input hit, input slot, input replaced, output ready);
endinterface

@@ src/ltts_tag_ram.sv @@
// key and timestamp memories, one write port each and a shared registered read
module ltts_tag_ram (
   input  logic                              clock,
   input  ltts_pkg::ram_wr_type              wr,
   input  logic [ltts_pkg::IDX_W-1:0]        rd_addr,
   output logic [ltts_pkg::KEY_W-1:0]        rd_key,
   output logic [ltts_pkg::STAMP_W-1:0]      rd_stamp
);

   logic [ltts_pkg::KEY_W-1:0]   key_mem   [ltts_pkg::MAX_ENTRIES];
   logic [ltts_pkg::STAMP_W-1:0] stamp_mem [ltts_pkg::MAX_ENTRIES];
   logic [ltts_pkg::KEY_W-1:0]   rd_key_ff;
   logic [ltts_pkg::STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr.addr] <= wr.key;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.stamp_we) begin
         stamp_mem[wr.addr] <= wr.stamp;
      end
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

@@ src/ltts_ctrl.sv @@
// sequencer: takes a request, scans the table downward, then updates it
module ltts_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   ltts_req_if.sink                         req_chan,
   input  logic [ltts_pkg::CAP_W-1:0]       capacity,
   input  logic                             out_free,
   output ltts_pkg::result_type             result,
   output ltts_pkg::ram_wr_type             ram_wr,
   output logic [ltts_pkg::IDX_W-1:0]       ram_rd_addr,
   input  logic [ltts_pkg::KEY_W-1:0]       ram_rd_key,
   input  logic [ltts_pkg::STAMP_W-1:0]     ram_rd_stamp
);

   localparam int unsigned CMP_W = ltts_pkg::CAP_W + ltts_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [ltts_pkg::ACT_W-1:0]       act_ff, act_in;
   logic [ltts_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [ltts_pkg::STAMP_W-1:0]     now_ff, now_in;
   logic [ltts_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ltts_pkg::IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                             issue_ff, issue_in;
   logic                             dat_vld_ff, dat_vld_in;
   logic [ltts_pkg::IDX_W-1:0]       dat_idx_ff, dat_idx_in;
   logic                             dat_last_ff, dat_last_in;
   logic                             found_ff, found_in;
   logic [ltts_pkg::IDX_W-1:0]       found_idx_ff, found_idx_in;
   logic [ltts_pkg::STAMP_W-1:0]     best_ff, best_in;
   logic [ltts_pkg::IDX_W-1:0]       victim_ff, victim_in;

   logic [ltts_pkg::CNT_W-1:0]       cnt_m1;
   logic [CMP_W-1:0]                 cap_ext;
   logic [CMP_W-1:0]                 eff_cap;
   logic                             has_room;

   assign cnt_m1      = cnt_ff - ltts_pkg::CNT_W'(1);
   assign ram_rd_addr = rd_idx_ff;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // capacity of zero acts as one, above the table size it saturates
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ltts_pkg::MAX_ENTRIES)) begin
         eff_cap = CMP_W'(ltts_pkg::MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      has_room = CMP_W'(cnt_ff) < eff_cap;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = 1'b0;
      dat_vld_in   = 1'b0;
      dat_idx_in   = rd_idx_ff;
      dat_last_in  = 1'b0;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      best_in      = best_ff;
      victim_in    = victim_ff;
      ram_wr       = '0;
      result       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in       = req_chan.action;
               key_in       = req_chan.key;
               now_in       = req_chan.now_ms;
               found_in     = 1'b0;
               found_idx_in = '0;
               // wraps to zero at the top of the time range, leaving slot 0
               best_in      = req_chan.now_ms + ltts_pkg::STAMP_W'(1);
               victim_in    = '0;
               rd_idx_in    = cnt_m1[ltts_pkg::IDX_W-1:0];
               if ((req_chan.action == ltts_pkg::ACT_LOOKUP ||
                    req_chan.action == ltts_pkg::ACT_STORE) && cnt_ff != '0) begin
                  state_in = ST_SCAN;
                  issue_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               dat_vld_in  = 1'b1;
               dat_idx_in  = rd_idx_ff;
               dat_last_in = (rd_idx_ff == '0);
               issue_in    = (rd_idx_ff != '0);
               rd_idx_in   = rd_idx_ff - ltts_pkg::IDX_W'(1);
            end
            if (dat_vld_ff) begin
               // first match walking down is the highest matching index
               if (!found_ff && ram_rd_key == key_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = dat_idx_ff;
               end
               // strict compare keeps ties at the higher index
               if (ram_rd_stamp < best_ff) begin
                  best_in   = ram_rd_stamp;
                  victim_in = dat_idx_ff;
               end
               if (dat_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               result.valid   = 1'b1;
               ram_wr.key     = key_ff;
               ram_wr.stamp   = now_ff;
               state_in       = ST_IDLE;
               unique case (act_ff)
                  ltts_pkg::ACT_LOOKUP: begin
                     if (found_ff) begin
                        result.hit      = 1'b1;
                        result.slot     = ltts_pkg::SLOT_W'(found_idx_ff);
                        ram_wr.addr     = found_idx_ff;
                        ram_wr.stamp_we = 1'b1;
                     end
                  end
                  ltts_pkg::ACT_STORE: begin
                     ram_wr.stamp_we = 1'b1;
                     if (found_ff) begin
                        result.hit  = 1'b1;
                        result.slot = ltts_pkg::SLOT_W'(found_idx_ff);
                        ram_wr.addr = found_idx_ff;
                     end else if (has_room) begin
                        result.slot   = ltts_pkg::SLOT_W'(cnt_ff);
                        ram_wr.addr   = ltts_pkg::IDX_W'(cnt_ff);
                        ram_wr.key_we = 1'b1;
                        cnt_in        = cnt_ff + ltts_pkg::CNT_W'(1);
                     end else begin
                        result.slot     = ltts_pkg::SLOT_W'(victim_ff);
                        result.replaced = 1'b1;
                        ram_wr.addr     = victim_ff;
                        ram_wr.key_we   = 1'b1;
                     end
                  end
                  ltts_pkg::ACT_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         issue_ff   <= 1'b0;
         dat_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         issue_ff   <= issue_in;
         dat_vld_ff <= dat_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      rd_idx_ff    <= rd_idx_in;
      dat_idx_ff   <= dat_idx_in;
      dat_last_ff  <= dat_last_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      best_ff      <= best_in;
      victim_ff    <= victim_in;
   end

endmodule

@@ src/lru_timestamp_tag_store.sv @@
// top level of the lru timestamp tag store: csr, sequencer, memories, response register
//
// fully associative store of up to 32 64-bit keys with a 32-bit usage stamp each.
// req_chan carries one beat per request: action (lookup, store, clear), key, now_ms.
// rsp_chan returns exactly one beat per request: hit, slot, replaced.
// csr_we/csr_wdata write the capacity register (entries kept before replacement).
// one request is worked at a time. a lookup or store reads every valid entry
// from the highest index down, one memory read per cycle; clear and an empty
// table skip the scan. the entry count sets the scan length.
// the response sits in an output register; the next request is accepted and
// scanned while it waits, and only its final update waits for rsp_chan.ready.
// reset empties the table (entry count zero) and sets the capacity to 32;
// memory contents are not cleared and entries past the count are never read.
module lru_timestamp_tag_store (
   input  logic                         clock,
   input  logic                         reset,
   ltts_req_if.sink                     req_chan,
   ltts_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [ltts_pkg::CAP_W-1:0]   csr_wdata
);

   logic [ltts_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [ltts_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                          rsp_replaced_ff, rsp_replaced_in;

   logic                          out_free;
   ltts_pkg::result_type          result;
   ltts_pkg::ram_wr_type          ram_wr;
   logic [ltts_pkg::IDX_W-1:0]    ram_rd_addr;
   logic [ltts_pkg::KEY_W-1:0]    ram_rd_key;
   logic [ltts_pkg::STAMP_W-1:0]  ram_rd_stamp;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   ltts_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .capacity     (cap_ff),
      .out_free     (out_free),
      .result       (result),
      .ram_wr       (ram_wr),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_key   (ram_rd_key),
      .ram_rd_stamp (ram_rd_stamp)
   );

   ltts_tag_ram u_tag_ram (
      .clock    (clock),
      .wr       (ram_wr),
      .rd_addr  (ram_rd_addr),
      .rd_key   (ram_rd_key),
      .rd_stamp (ram_rd_stamp)
   );

   always_comb begin
      cap_in          = csr_we ? csr_wdata : cap_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_replaced_in = rsp_replaced_ff;
      if (result.valid) begin
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = result.hit;
         rsp_slot_in     = result.slot;
         rsp_replaced_in = result.replaced;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= ltts_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_replaced_ff <= rsp_replaced_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.slot     = rsp_slot_ff;
   assign rsp_chan.replaced = rsp_replaced_ff;

endmodule

@@ tb/ltts_checker.sv @@
`timescale 1ns / 100ps
// checker of the tag store: mirrors the table, predicts each response beat and compares it
module ltts_checker
   import ltts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [KEY_W-1:0]         req_key,
   input  logic [STAMP_W-1:0]       req_now_ms,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     rsp_hit,
   input  logic [SLOT_W-1:0]        rsp_slot,
   input  logic                     rsp_replaced,
   input  logic                     csr_we,
   input  logic [CAP_W-1:0]         csr_wdata,
   output int                       mismatch_count,
   output int                       rsp_outstanding
);

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              replaced;
   } tag_rsp_t;

   logic [KEY_W-1:0]   key_tab   [MAX_ENTRIES];
   logic [STAMP_W-1:0] stamp_tab [MAX_ENTRIES];
   int unsigned        fill;
   logic [CAP_W-1:0]   capacity;
   tag_rsp_t           awaited_rsp_q [$];

   initial begin
      mismatch_count  = 0;
      rsp_outstanding = 0;
      fill            = 0;
      capacity        = CAP_RESET;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // works one request against the mirrored table and returns its response
   function automatic tag_rsp_t tag_store_update(input logic [ACT_W-1:0] act,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [STAMP_W-1:0] now);
      tag_rsp_t           r;
      int                 found;
      int unsigned        limit;
      logic [STAMP_W-1:0] best;
      int unsigned        victim;
      r     = '0;
      found = -1;
      for (int i = int'(fill) - 1; i >= 0; i--) begin
         if (found < 0 && key_tab[i] == k) found = i;
      end
      limit = (capacity == 0) ? 1 : ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity);
      case (act)
         ACT_LOOKUP: begin
            if (found >= 0) begin
               r.hit            = 1'b1;
               r.slot           = SLOT_W'(found);
               stamp_tab[found] = now;
            end
         end
         ACT_STORE: begin
            if (found >= 0) begin
               r.hit  = 1'b1;
               r.slot = SLOT_W'(found);
            end else if (fill < limit) begin
               r.slot        = SLOT_W'(fill);
               key_tab[fill] = k;
               fill++;
            end else begin
               // oldest stamp below now+1, ties to the highest index, slot 0 if none
               best   = now + STAMP_W'(1);
               victim = 0;
               for (int i = int'(fill) - 1; i >= 0; i--) begin
                  if (stamp_tab[i] < best) begin
                     best   = stamp_tab[i];
                     victim = i;
                  end
               end
               r.slot          = SLOT_W'(victim);
               key_tab[victim] = k;
               r.replaced      = 1'b1;
            end
            stamp_tab[r.slot] = now;
         end
         ACT_CLEAR: fill = 0;
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      tag_rsp_t want;
      if (reset) begin
         capacity = CAP_RESET;
         fill     = 0;
         awaited_rsp_q.delete();
      end else begin
         if (csr_we) capacity = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response beat with no request waiting, slot %0d",
                                         rsp_slot));
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit got %0d expected %0d", rsp_hit, want.hit));
               if (rsp_slot !== want.slot)
                  report_mismatch($sformatf("slot got %0d expected %0d", rsp_slot, want.slot));
               if (rsp_replaced !== want.replaced)
                  report_mismatch($sformatf("replaced got %0d expected %0d",
                                            rsp_replaced, want.replaced));
            end
         end
         if (req_valid && req_ready)
            awaited_rsp_q.push_back(tag_store_update(req_action, req_key, req_now_ms));
      end
      rsp_outstanding = awaited_rsp_q.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench top of the tag store: clock, reset, stimulus, watchdog and verdict
module tb_top;
   import ltts_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 2000;
   localparam int SEG_ITEMS    = 96;
   localparam int NUM_SEGS     = 12;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 40;
   localparam int POOL_MAX     = 40;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;
   int               mismatch_count;
   int               rsp_outstanding;
   int               send_idle_pct;
   int               rcv_idle_pct;
   int               stall_cycles;
   logic [STAMP_W-1:0] clock_ms;

   ltts_req_if req_chan ();
   ltts_rsp_if rsp_chan ();

   lru_timestamp_tag_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ltts_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_action      (req_chan.action),
      .req_key         (req_chan.key),
      .req_now_ms      (req_chan.now_ms),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_hit         (rsp_chan.hit),
      .rsp_slot        (rsp_chan.slot),
      .rsp_replaced    (rsp_chan.replaced),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .rsp_outstanding (rsp_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side stalls
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // no beat on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high into the next beat
   task automatic send_beat(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                            input logic [STAMP_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.key    <= k;
      req_chan.now_ms <= now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain(input int extra);
      while (rsp_outstanding != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] v);
      req_chan.valid <= 1'b0;
      drain(DRAIN_CYCLES);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [KEY_W-1:0] key_a, key_b, key_c, key_d, key_e, key_f, k;
      logic [KEY_W-1:0] key_pool [POOL_MAX];
      logic [ACT_W-1:0] act;
      int               seg_caps [NUM_SEGS];
      int               eff, pool_n, r;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.action = ACT_LOOKUP;
      req_chan.key    = '0;
      req_chan.now_ms = '0;
      send_idle_pct   = 34;
      rcv_idle_pct    = 53;
      stall_cycles    = 0;
      clock_ms        = '0;
      seg_caps        = '{1, 32, 5, 0, 63, 3, 17, 32, 2, 8, 40, 31};
      key_a = {$urandom, $urandom};
      key_b = {$urandom, $urandom};
      key_c = {$urandom, $urandom};
      key_d = {$urandom, $urandom};
      key_e = {$urandom, $urandom};
      key_f = {$urandom, $urandom};

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed part
      set_capacity(4);
      send_beat(ACT_LOOKUP, '0, '0);
      send_beat(ACT_STORE, 64'h8000_0000_0000_0000, 10);
      send_beat(ACT_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 10);
      send_beat(ACT_STORE, '0, 20);
      send_beat(ACT_STORE, '1, 32'hFFFF_FFFE);
      send_beat(ACT_LOOKUP, 64'h8000_0000_0000_0000, 30);
      send_beat(ACT_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 30);
      // no stamp lies below now+1, so slot 0 goes
      send_beat(ACT_STORE, key_a, 5);
      // now+1 wraps to zero
      send_beat(ACT_STORE, key_b, 32'hFFFF_FFFF);
      send_beat(ACT_STORE, key_c, 100);
      send_beat(ACT_UNUSED, key_c, 100);
      send_beat(ACT_LOOKUP, key_a, 101);
      // capacity below the entry count keeps the entries
      set_capacity(2);
      send_beat(ACT_STORE, key_d, 200);
      send_beat(ACT_LOOKUP, key_d, 201);
      send_beat(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 202);
      send_beat(ACT_CLEAR, '1, 32'hFFFF_FFFF);
      send_beat(ACT_LOOKUP, key_d, 203);
      // zero capacity acts as one
      set_capacity(0);
      send_beat(ACT_STORE, key_e, 1);
      send_beat(ACT_STORE, key_f, 1);
      send_beat(ACT_LOOKUP, key_e, 2);
      // capacity above the table size saturates
      set_capacity(63);
      send_beat(ACT_STORE, key_e, 3);
      send_beat(ACT_STORE, key_f, 3);

      // random part: segments with their own capacity and key pool
      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         if (seg == NUM_SEGS / 3) begin
            send_idle_pct = 53;
            rcv_idle_pct  = 34;
         end else if (seg == 2 * NUM_SEGS / 3) begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         set_capacity(seg_caps[seg]);
         eff    = (seg_caps[seg] == 0) ? 1 :
                  ((seg_caps[seg] > MAX_ENTRIES) ? MAX_ENTRIES : seg_caps[seg]);
         pool_n = (eff + 4 > POOL_MAX) ? POOL_MAX : eff + 4;
         for (int i = 0; i < POOL_MAX; i++) key_pool[i] = {$urandom, $urandom};
         for (int n = 0; n < SEG_ITEMS; n++) begin
            r = $urandom_range(199);
            if (r < 76)       act = ACT_LOOKUP;
            else if (r < 190) act = ACT_STORE;
            else if (r < 194) act = ACT_CLEAR;
            else              act = ACT_UNUSED;
            if ($urandom_range(19) == 0)
               k = {$urandom, $urandom};
            else
               k = key_pool[$urandom_range(pool_n - 1)];
            // time mostly creeps forward with ties, sometimes jumps, wraps or goes back
            r = $urandom_range(99);
            if (r < 80)       clock_ms = clock_ms + $urandom_range(3);
            else if (r < 88)  clock_ms = $urandom;
            else if (r < 92)  clock_ms = '1;
            else if (r < 96)  clock_ms = clock_ms - $urandom_range(50);
            else              clock_ms = '0;
            send_beat(act, k, clock_ms);
         end
      end

      req_chan.valid <= 1'b0;
      drain(TAIL_CYCLES);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
